>>> src/int4_lut_dot_product_two_rows_core_macros.svh
// assertion macros for the two-row lookup dot product core
// used by the top level; expects signals named clk and rst in scope
`ifndef INT4_LUT_DOT_PRODUCT_TWO_ROWS_CORE_MACROS_SVH
`define INT4_LUT_DOT_PRODUCT_TWO_ROWS_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define I4DP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define I4DP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/i4dp_pkg.sv
// shared widths, defaults and control structs for the two-row lookup dot product
// no dependencies
package i4dp_pkg;

  // default packing of one weight word
  localparam int DEF_CODES_PER_WORD = 8;
  localparam int DEF_CODE_BITS      = 4;

  // fixed field widths
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 8;
  localparam int NUM_ACTS  = 8;
  localparam int ACTS_W    = ACT_W * NUM_ACTS;
  localparam int INDEX_W   = 4;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = ACT_W + VAL_W;
  localparam int SUM_W     = 32;

  // request kinds
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_ACCUM = 1'b1;

  // table row select
  localparam logic ROW_0 = 1'b0;
  localparam logic ROW_1 = 1'b1;

  // per-lane control from the pipeline controller
  typedef struct packed {
    logic wr_en;
    logic wr_row;
    logic rd_en;
    logic mul_en;
  } lane_ctrl_t;

  // merge stage control
  typedef struct packed {
    logic sum_en;
    logic acc_en;
    logic emit;
  } merge_ctrl_t;

endpackage

>>> src/i4dp_in_if.sv
// input channel: valid/ready handshake carrying one load or accumulate request
// depends on i4dp_pkg
interface i4dp_in_if;
  import i4dp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic                     table_row;
  logic [INDEX_W-1:0]       table_index;
  logic signed [VAL_W-1:0]  table_value;
  logic [WORD_W-1:0]        weights_row0;
  logic [WORD_W-1:0]        weights_row1;
  logic [ACTS_W-1:0]        activations;
  logic                     last;

  modport source (
    output valid, action, table_row, table_index, table_value,
           weights_row0, weights_row1, activations, last,
    input  ready
  );

  modport sink (
    input  valid, action, table_row, table_index, table_value,
           weights_row0, weights_row1, activations, last,
    output ready
  );

endinterface

>>> src/i4dp_out_if.sv
// output channel: valid/ready handshake carrying the two row sums
// depends on i4dp_pkg
interface i4dp_out_if;
  import i4dp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  sum_row0;
  logic signed [SUM_W-1:0]  sum_row1;

  modport source (
    output valid, sum_row0, sum_row1,
    input  ready
  );

  modport sink (
    input  valid, sum_row0, sum_row1,
    output ready
  );

endinterface

>>> src/int4_lut_dot_product_two_rows_core.sv
// Two-row lookup dot product core: parallel lanes, adder tree, wrapping accumulators.
// Throughput: one request per cycle, load or accumulate, when the output is not blocked.
// Path: a last accumulate request passes the table lookup, multiply and tree sum registers;
//   the accumulator add then feeds the output register.
// Reset clears the pipeline, accumulators and output valid; table entries stay
//   undefined until loaded. Depends on i4dp_pkg, i4dp_in_if, i4dp_out_if, lanes, merge.
`include "int4_lut_dot_product_two_rows_core_macros.svh"

module int4_lut_dot_product_two_rows_core #(
  parameter int CODES_PER_WORD = i4dp_pkg::DEF_CODES_PER_WORD,
  parameter int CODE_BITS      = i4dp_pkg::DEF_CODE_BITS
) (
  input logic        clk,
  input logic        rst,
  i4dp_in_if.sink    in_ch,
  i4dp_out_if.source out_ch
);
  import i4dp_pkg::*;

  logic                     v1, v2, v3;
  logic                     last1, last2, last3;
  logic                     out_v;
  logic                     leave3, load1, load2, load3;
  logic                     accept;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  logic [CODE_BITS-1:0]     wr_addr;
  logic [WORD_W+CODE_BITS-1:0] w0_ext;
  logic [WORD_W+CODE_BITS-1:0] w1_ext;
  logic [CODE_BITS-1:0]     code0 [CODES_PER_WORD];
  logic [CODE_BITS-1:0]     code1 [CODES_PER_WORD];
  logic signed [ACT_W-1:0]  act [CODES_PER_WORD];
  logic signed [PROD_W-1:0] prod0 [CODES_PER_WORD];
  logic signed [PROD_W-1:0] prod1 [CODES_PER_WORD];

  // stall chain back from the output register
  assign leave3 = !last3 || !out_v || out_ch.ready;
  assign load3  = !v3 || leave3;
  assign load2  = !v2 || load3;
  assign load1  = !v1 || load2;

  assign in_ch.ready = load1;
  assign accept      = in_ch.valid && load1;

  assign wr_addr = (CODE_BITS)'(in_ch.table_index);

  // lane and merge control
  always_comb begin
    lane_ctrl.wr_en    = accept && in_ch.action == ACTION_LOAD;
    lane_ctrl.wr_row   = in_ch.table_row;
    lane_ctrl.rd_en    = load1;
    lane_ctrl.mul_en   = load2;
    merge_ctrl.sum_en  = load3;
    merge_ctrl.acc_en  = v3 && leave3;
    merge_ctrl.emit    = v3 && last3 && leave3;
  end

  // pipeline valid and last flags, loads stop at the tables
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      last1 <= 1'b0;
      last2 <= 1'b0;
      last3 <= 1'b0;
    end else begin
      if (load1) begin
        v1    <= accept && in_ch.action == ACTION_ACCUM;
        last1 <= in_ch.last;
      end
      if (load2) begin
        v2    <= v1;
        last2 <= last1;
      end
      if (load3) begin
        v3    <= v2;
        last3 <= last2;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (merge_ctrl.emit) begin
      out_v <= 1'b1;
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  assign out_ch.valid = out_v;

  // weight words padded so a code past bit 31 reads zero bits
  assign w0_ext = {{CODE_BITS{1'b0}}, in_ch.weights_row0};
  assign w1_ext = {{CODE_BITS{1'b0}}, in_ch.weights_row1};

  // per-position code and activation selection, then the lanes
  for (genvar k = 0; k < CODES_PER_WORD; k++) begin : g_lane
    localparam int SH = k * CODE_BITS;

    if (SH < WORD_W) begin : g_code
      assign code0[k] = w0_ext[SH +: CODE_BITS];
      assign code1[k] = w1_ext[SH +: CODE_BITS];
    end else begin : g_nocode
      assign code0[k] = '0;
      assign code1[k] = '0;
    end

    if (k < NUM_ACTS) begin : g_act
      assign act[k] = in_ch.activations[k*ACT_W +: ACT_W];
    end else begin : g_noact
      assign act[k] = '0;
    end

    i4dp_lane #(
      .CODE_BITS (CODE_BITS)
    ) u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .wr_addr (wr_addr),
      .wr_data (in_ch.table_value),
      .code0   (code0[k]),
      .code1   (code1[k]),
      .act     (act[k]),
      .prod0   (prod0[k]),
      .prod1   (prod1[k])
    );
  end

  // adder tree and accumulators
  i4dp_merge #(
    .CODES_PER_WORD (CODES_PER_WORD)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (merge_ctrl),
    .prod0    (prod0),
    .prod1    (prod1),
    .sum_row0 (out_ch.sum_row0),
    .sum_row1 (out_ch.sum_row1)
  );

  // checks on the pipeline control
  `I4DP_ASSERT_NEXT(a_emit_sets_valid, merge_ctrl.emit, out_v, "result lost after emit")
  `I4DP_ASSERT_NOW(a_ready_when_empty, !v1 && !v2 && !v3, in_ch.ready, "ready low with empty pipe")
  `I4DP_ASSERT_NEXT(a_load_not_piped, accept && in_ch.action == ACTION_LOAD, !v1, "load entered pipe")
  `I4DP_ASSERT_NEXT(a_blocked_last_held, v3 && !leave3, v3 && last3, "blocked last request dropped")

endmodule

>>> src/i4dp_lane.sv
// one multiply lane: private copy of both row tables, registered lookup, product register
// depends on i4dp_pkg
module i4dp_lane #(
  parameter int CODE_BITS = i4dp_pkg::DEF_CODE_BITS
) (
  input  logic                             clk,
  input  i4dp_pkg::lane_ctrl_t             ctrl,
  input  logic [CODE_BITS-1:0]             wr_addr,
  input  logic signed [i4dp_pkg::VAL_W-1:0] wr_data,
  input  logic [CODE_BITS-1:0]             code0,
  input  logic [CODE_BITS-1:0]             code1,
  input  logic signed [i4dp_pkg::ACT_W-1:0] act,
  output logic signed [i4dp_pkg::PROD_W-1:0] prod0,
  output logic signed [i4dp_pkg::PROD_W-1:0] prod1
);
  import i4dp_pkg::*;

  localparam int TABLE_SIZE = 1 << CODE_BITS;

  logic signed [VAL_W-1:0] mem0 [TABLE_SIZE];
  logic signed [VAL_W-1:0] mem1 [TABLE_SIZE];

  logic signed [VAL_W-1:0] rdata0;
  logic signed [VAL_W-1:0] rdata1;
  logic signed [ACT_W-1:0] act_q;

  // table writes, broadcast to every lane
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_row == ROW_0) begin
      mem0[wr_addr] <= wr_data;
    end
    if (ctrl.wr_en && ctrl.wr_row == ROW_1) begin
      mem1[wr_addr] <= wr_data;
    end
  end

  // registered lookup, activation travels alongside
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata0 <= mem0[code0];
      rdata1 <= mem1[code1];
      act_q  <= act;
    end
  end

  // signed 8 x 16 products
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod0 <= PROD_W'(act_q) * PROD_W'(rdata0);
      prod1 <= PROD_W'(act_q) * PROD_W'(rdata1);
    end
  end

endmodule

>>> src/i4dp_merge.sv
// merge stage: adder tree over the lane products, then the wrapping row accumulators
// depends on i4dp_pkg
module i4dp_merge #(
  parameter int CODES_PER_WORD = i4dp_pkg::DEF_CODES_PER_WORD
) (
  input  logic                              clk,
  input  logic                              rst,
  input  i4dp_pkg::merge_ctrl_t             ctrl,
  input  logic signed [i4dp_pkg::PROD_W-1:0] prod0 [CODES_PER_WORD],
  input  logic signed [i4dp_pkg::PROD_W-1:0] prod1 [CODES_PER_WORD],
  output logic signed [i4dp_pkg::SUM_W-1:0]  sum_row0,
  output logic signed [i4dp_pkg::SUM_W-1:0]  sum_row1
);
  import i4dp_pkg::*;

  localparam int TREE_N = 1 << $clog2(CODES_PER_WORD);

  logic signed [SUM_W-1:0] node0 [2*TREE_N-1];
  logic signed [SUM_W-1:0] node1 [2*TREE_N-1];
  logic signed [SUM_W-1:0] part0;
  logic signed [SUM_W-1:0] part1;
  logic signed [SUM_W-1:0] acc0;
  logic signed [SUM_W-1:0] acc1;
  logic signed [SUM_W-1:0] acc0_next;
  logic signed [SUM_W-1:0] acc1_next;

  // tree leaves, padded with zero up to a power of two
  for (genvar j = 0; j < TREE_N; j++) begin : g_leaf
    if (j < CODES_PER_WORD) begin : g_used
      assign node0[TREE_N-1+j] = SUM_W'(prod0[j]);
      assign node1[TREE_N-1+j] = SUM_W'(prod1[j]);
    end else begin : g_pad
      assign node0[TREE_N-1+j] = '0;
      assign node1[TREE_N-1+j] = '0;
    end
  end

  // tree inner nodes, sums wrap at 32 bits
  for (genvar i = 0; i < TREE_N - 1; i++) begin : g_node
    assign node0[i] = node0[2*i+1] + node0[2*i+2];
    assign node1[i] = node1[2*i+1] + node1[2*i+2];
  end

  // registered partial sums of one request
  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      part0 <= node0[0];
      part1 <= node1[0];
    end
  end

  assign acc0_next = acc0 + part0;
  assign acc1_next = acc1 + part1;

  // running accumulators, cleared when a result goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      acc0 <= '0;
      acc1 <= '0;
    end else if (ctrl.acc_en) begin
      if (ctrl.emit) begin
        acc0 <= '0;
        acc1 <= '0;
      end else begin
        acc0 <= acc0_next;
        acc1 <= acc1_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      sum_row0 <= acc0_next;
      sum_row1 <= acc1_next;
    end
  end

endmodule
